>>> design/lfsb_pkg.sv
// Shared types, constants and state encodings for the lidar frame scan binner.
package lfsb_pkg;

  localparam int SCAN_ENTRIES_DEF = 720;

  // Width of the angle numerator start*(n-1-j) + end*j for 16-bit angles and 8-bit weights.
  localparam int NUM_W = 24;
  // Width of the divisor 360*(n-1), with n-1 at most 254.
  localparam int DEN_W = 17;
  // Width of the entry index field on the result channel.
  localparam int IDX_OUT_W = 10;

  localparam logic [7:0]       HDR_FIRST  = 8'h55;
  localparam logic [7:0]       HDR_SECOND = 8'hAA;
  localparam logic [DEN_W-1:0] DEG_FULL   = 17'd360;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  entry_index;
    logic [15:0] distance;
  } out_item_t;

  // Everything the index calculation needs for one distance sample.
  typedef struct packed {
    logic [7:0]  n1;
    logic [7:0]  j;
    logic [15:0] start_angle;
    logic [15:0] stop_angle;
    logic [15:0] dist_val;
  } sample_t;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_HDR2,
    PH_TYPE,
    PH_COUNT,
    PH_START_LO,
    PH_START_HI,
    PH_END_LO,
    PH_END_HI,
    PH_CHK1,
    PH_CHK2,
    PH_DIST_LO,
    PH_DIST_HI
  } phase_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NUM,
    B_SCALE,
    B_START1,
    B_DIV1,
    B_MOD,
    B_FIN
  } bin_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } top_state_t;

endpackage

>>> design/lidar_frame_scan_binner_top.sv
// Top level of the lidar frame scan binner: sequencing, scan memory access and result register.
//
// Each input transaction carries either one byte of the lidar serial stream or a read
// command for one scan entry. The parser looks for the 0x55 0xAA header, skips the type
// byte, takes the sample count and the little-endian start and end angles, skips the two
// check bytes and then assembles the distances. Every distance is written to the scan entry
// floor((start*(n-1) + (end-start)*j) * SCAN_ENTRIES / (360*(n-1))) mod SCAN_ENTRIES and
// reported as a sample transaction; a read command is answered with a read reply, with
// distance zero when the index lies beyond the scan. A byte that completes no distance
// produces no result. A read passes the read-data state, which registers its reply, and
// the emit state, which moves the reply into the output register. For the high byte of a
// distance the floor division comes from a bit-serial divider, and the wrap to the scan
// size from eight compare-and-subtract steps. After reset the block clears the scan
// memory one entry per cycle and holds in_stall high until the clearing sweep ends. A
// finished result waits in the output register while the next input transaction is taken.
module lidar_frame_scan_binner_top #(
  parameter int SCAN_ENTRIES = lfsb_pkg::SCAN_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfsb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lfsb_pkg::out_item_t out_data
);
  import lfsb_pkg::*;

  localparam int IW = (SCAN_ENTRIES > 1) ? $clog2(SCAN_ENTRIES) : 1;

  top_state_t state_r, state_nxt;

  logic      in_acc;
  logic      is_read;
  logic      byte_en;
  logic      bin_start;
  logic      out_load;

  logic      clr_busy;
  logic [15:0] mem_rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW+9:0] rd_addr_ext;
  logic [IW+9:0] bin_idx_ext;

  logic      at_sample;
  sample_t   sample;
  logic      bin_done;
  logic [IW-1:0] bin_idx;

  logic [9:0]  rd_idx_r;
  logic        range_ok_r;
  logic [15:0] dist_hold_r;
  out_item_t   res_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  // The read index is narrowed or widened to the memory address width. An index beyond the
  // scan may alias onto a real entry, but its reply is forced to zero.
  always_comb begin
    rd_addr_ext = {{IW{1'b0}}, in_data.read_index};
    rd_addr     = rd_addr_ext[IW-1:0];
    bin_idx_ext = {10'b0, bin_idx};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_read) state_nxt = ST_READ;
        else if (bin_start) state_nxt = ST_CALC;
      end
      ST_READ: state_nxt = ST_EMIT;
      ST_CALC: if (bin_done) state_nxt = ST_EMIT;
      ST_EMIT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = clr_busy || (state_r != ST_IDLE);
    in_acc    = in_valid && !in_stall;
    is_read   = (in_data.cmd == CMD_READ);
    byte_en   = in_acc && !is_read;
    bin_start = byte_en && at_sample;
    out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_read) begin
      rd_idx_r   <= in_data.read_index;
      range_ok_r <= ({22'b0, in_data.read_index} < 32'(SCAN_ENTRIES));
    end
    if (bin_start) dist_hold_r <= sample.dist_val;
    if (state_r == ST_READ) begin
      res_r.kind        <= KIND_READ;
      res_r.entry_index <= rd_idx_r;
      res_r.distance    <= range_ok_r ? mem_rd_data : 16'd0;
    end
    if (bin_done) begin
      res_r.kind        <= KIND_SAMPLE;
      res_r.entry_index <= bin_idx_ext[IDX_OUT_W-1:0];
      res_r.distance    <= dist_hold_r;
    end
    if (out_load) out_data_r <= res_r;
  end

  lfsb_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_data.rx_byte),
    .at_sample (at_sample),
    .sample    (sample)
  );

  lfsb_binner #(
    .ENTRIES (SCAN_ENTRIES),
    .IW      (IW)
  ) u_binner (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bin_start),
    .smp   (sample),
    .done  (bin_done),
    .idx   (bin_idx)
  );

  // The write of a sample lands before the next transaction is accepted, so a read that
  // follows always sees it.
  lfsb_scan_mem #(
    .ENTRIES (SCAN_ENTRIES),
    .IW      (IW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (bin_done),
    .wr_addr  (bin_idx),
    .wr_data  (dist_hold_r),
    .rd_en    (in_acc && is_read),
    .rd_addr  (rd_addr),
    .rd_data  (mem_rd_data),
    .clr_busy (clr_busy)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The index calculation only finishes while the sequencer waits for it.
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    bin_done |-> (state_r == ST_CALC))
    else $error("bin index finished outside the calculation state");

  // No sample is written into the memory while the clearing sweep runs.
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !bin_done)
    else $error("scan memory written during the clearing sweep");

  // An accepted read command moves to the read-data cycle right after acceptance.
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_read) |=> (state_r == ST_READ))
    else $error("read command did not enter the read-data cycle");

endmodule

>>> design/lfsb_parser.sv
// Frame parser: header search, frame fields and assembly of little-endian distances.
module lfsb_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [7:0]        rx_byte,
  output logic              at_sample,
  output lfsb_pkg::sample_t sample
);
  import lfsb_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] total_r;
  logic [7:0] number_r;
  logic [15:0] start_r;
  logic [15:0] stop_r;
  logic [7:0] low_r;

  logic ld_total, ld_low, ld_start, ld_stop, inc_number;

  always_comb begin
    phase_nxt = phase_r;
    if (byte_en) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == HDR_FIRST) phase_nxt = PH_HDR2;
        end
        PH_HDR2: begin
          if (rx_byte == HDR_SECOND) phase_nxt = PH_TYPE;
          else if (rx_byte != HDR_FIRST) phase_nxt = PH_HUNT;
        end
        PH_TYPE:     phase_nxt = PH_COUNT;
        PH_COUNT:    phase_nxt = PH_START_LO;
        PH_START_LO: phase_nxt = PH_START_HI;
        PH_START_HI: phase_nxt = PH_END_LO;
        PH_END_LO:   phase_nxt = PH_END_HI;
        PH_END_HI:   phase_nxt = PH_CHK1;
        PH_CHK1:     phase_nxt = PH_CHK2;
        PH_CHK2:     phase_nxt = (total_r == 8'd0) ? PH_HUNT : PH_DIST_LO;
        PH_DIST_LO:  phase_nxt = PH_DIST_HI;
        PH_DIST_HI: begin
          phase_nxt = ((number_r + 8'd1) >= total_r) ? PH_HUNT : PH_DIST_LO;
        end
        default:     phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    ld_total   = byte_en && (phase_r == PH_COUNT);
    ld_low     = byte_en && ((phase_r == PH_START_LO) || (phase_r == PH_END_LO) ||
                             (phase_r == PH_DIST_LO));
    ld_start   = byte_en && (phase_r == PH_START_HI);
    ld_stop    = byte_en && (phase_r == PH_END_HI);
    inc_number = byte_en && (phase_r == PH_DIST_HI);
    at_sample  = (phase_r == PH_DIST_HI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      total_r  <= '0;
      number_r <= '0;
      start_r  <= '0;
      stop_r   <= '0;
      low_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (ld_total) begin
        total_r  <= rx_byte;
        number_r <= '0;
      end
      if (ld_low)     low_r    <= rx_byte;
      if (ld_start)   start_r  <= {rx_byte, low_r};
      if (ld_stop)    stop_r   <= {rx_byte, low_r};
      if (inc_number) number_r <= number_r + 8'd1;
    end
  end

  // A frame of one sample sits at the start angle, which the general form gives with
  // n-1 taken as one and j as zero.
  always_comb begin
    sample.n1          = (total_r < 8'd2) ? 8'd1 : (total_r - 8'd1);
    sample.j           = (total_r < 8'd2) ? 8'd0 : number_r;
    sample.start_angle = start_r;
    sample.stop_angle  = stop_r;
    sample.dist_val    = {rx_byte, low_r};
  end

endmodule

>>> design/lfsb_div.sv
// Restoring divider that produces one quotient bit per cycle.
module lfsb_div #(
  parameter int DW = 34,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import lfsb_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dsr_r;

  logic [VW:0] shifted;
  logic [VW:0] diff;
  logic        fits;

  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    diff    = shifted - {1'b0, dsr_r};
    fits    = (shifted >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], fits};
      rem_r <= fits ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/lfsb_binner.sv
// Scan index calculation: angle numerator, scaling, floor division and wrap to the scan size.
module lfsb_binner #(
  parameter int ENTRIES = lfsb_pkg::SCAN_ENTRIES_DEF,
  parameter int IW      = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lfsb_pkg::sample_t smp,
  output logic              done,
  output logic [IW-1:0]     idx
);
  import lfsb_pkg::*;

  localparam int EW = $clog2(ENTRIES + 1);
  localparam int DW = NUM_W + EW;
  localparam logic [DW-1:0] ENT_D = DW'(ENTRIES);
  // The quotient never reaches 183 scan sizes, so conditional subtraction of the scan size
  // times 128, 64, ... 1 leaves the wrapped index.
  localparam logic [2:0]    MOD_STEP_TOP = 3'd7;

  bin_state_t state_r, state_nxt;

  logic [7:0]       n1_r;
  logic [7:0]       j_r;
  logic [15:0]      start_r;
  logic [15:0]      stop_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DW-1:0]    scaled_r;
  logic [DW-1:0]    mod_r;
  logic [2:0]       step_r;

  logic [7:0]       wgt_a;
  logic [NUM_W-1:0] prod_a;
  logic [NUM_W-1:0] prod_b;
  logic [NUM_W:0]   num_sum;
  logic [DW-1:0]    mod_sub;
  logic [DW-1:0]    mod_diff;
  logic             mod_fits;

  logic             div_start;
  logic             div_done;
  logic [DW-1:0]    div_quo;

  // With j never above n-1 the numerator is a weighted sum of the two angles and stays
  // non-negative, so the floor division is an ordinary unsigned one.
  always_comb begin
    wgt_a   = n1_r - j_r;
    prod_a  = start_r * wgt_a;
    prod_b  = stop_r * j_r;
    num_sum = {1'b0, prod_a} + {1'b0, prod_b};
  end

  always_comb begin
    mod_sub  = ENT_D << step_r;
    mod_fits = (mod_r >= mod_sub);
    mod_diff = mod_r - mod_sub;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (start) state_nxt = B_NUM;
      B_NUM:    state_nxt = B_SCALE;
      B_SCALE:  state_nxt = B_START1;
      B_START1: state_nxt = B_DIV1;
      B_DIV1:   if (div_done) state_nxt = B_MOD;
      B_MOD:    if (step_r == 3'd0) state_nxt = B_FIN;
      B_FIN:    state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    done      = 1'b0;
    case (state_r)
      B_START1: div_start = 1'b1;
      B_FIN:    done = 1'b1;
      default:  div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == B_IDLE)) begin
      n1_r    <= smp.n1;
      j_r     <= smp.j;
      start_r <= smp.start_angle;
      stop_r  <= smp.stop_angle;
    end
    if (state_r == B_NUM) begin
      num_r <= num_sum[NUM_W-1:0];
      den_r <= DEN_W'(n1_r) * DEG_FULL;
    end
    if (state_r == B_SCALE) begin
      scaled_r <= DW'(num_r) * ENT_D;
    end
    if ((state_r == B_DIV1) && div_done) begin
      mod_r  <= div_quo;
      step_r <= MOD_STEP_TOP;
    end
    if (state_r == B_MOD) begin
      if (mod_fits) mod_r <= mod_diff;
      step_r <= step_r - 3'd1;
    end
  end

  lfsb_div #(
    .DW (DW),
    .VW (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (scaled_r),
    .divisor   (den_r),
    .done      (div_done),
    .quotient  (div_quo)
  );

  assign idx = mod_r[IW-1:0];

endmodule

>>> design/lfsb_scan_mem.sv
// Scan memory with one write and one registered read port and a clearing sweep after reset.
module lfsb_scan_mem #(
  parameter int ENTRIES = lfsb_pkg::SCAN_ENTRIES_DEF,
  parameter int IW      = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  output logic          clr_busy
);
  import lfsb_pkg::*;

  logic [15:0]   mem [ENTRIES];
  logic [15:0]   rd_data_r;
  logic          clr_active_r;
  logic [IW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IW'(ENTRIES - 1)) clr_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_active_r;

endmodule
